// ----- rtl/sdc_pkg.sv -----
package sdc_pkg;

   // default sizes
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 16;

   // register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      CSR_ATTACK    = 3'd0,
      CSR_RELEASE   = 3'd1,
      CSR_THRESHOLD = 3'd2,
      CSR_DEPTH     = 3'd3,
      CSR_EXT_KEY   = 3'd4
   } sdc_csr_index_type;

   // reset values, truncated to the register widths where used
   localparam int ATTACK_RESET    = 64856;
   localparam int RELEASE_RESET   = 65528;
   localparam int THRESHOLD_RESET = 32767;
   localparam int DEPTH_RESET     = 0;

   // sequencer states, one pass of the shared multiplier per *_MUL state
   typedef enum logic [2:0] {
      S_IDLE,
      S_ENV_MUL,
      S_ENV,
      S_RED_MUL,
      S_GAIN,
      S_L_MUL,
      S_R_MUL,
      S_DONE
   } sdc_state_type;

endpackage

// ----- rtl/sdc_csr.sv -----
module sdc_csr
   import sdc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   paddr,
   input  logic [CSR_DATA_BITS-1:0]   pwdata,
   output logic [CSR_DATA_BITS-1:0]   prdata,
   output logic [COEF_BITS-1:0]       attack_coef,
   output logic [COEF_BITS-1:0]       release_coef,
   output logic [SAMPLE_BITS-2:0]     duck_threshold,
   output logic [COEF_BITS-1:0]       duck_depth,
   output logic                       use_external_key
);

   localparam int FRAC_BITS = SAMPLE_BITS - 1;

   logic [COEF_BITS-1:0] attack_ff;
   logic [COEF_BITS-1:0] release_ff;
   logic [FRAC_BITS-1:0] threshold_ff;
   logic [COEF_BITS-1:0] depth_ff;
   logic                 ext_key_ff;
   logic                 wr_en;
   logic [2:0]           index;

   assign wr_en = psel && penable && pwrite;
   assign index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff    <= COEF_BITS'(ATTACK_RESET);
         release_ff   <= COEF_BITS'(RELEASE_RESET);
         threshold_ff <= FRAC_BITS'(THRESHOLD_RESET);
         depth_ff     <= COEF_BITS'(DEPTH_RESET);
         ext_key_ff   <= 1'b1;
      end else if (wr_en) begin
         case (index)
            CSR_ATTACK:    attack_ff    <= pwdata[COEF_BITS-1:0];
            CSR_RELEASE:   release_ff   <= pwdata[COEF_BITS-1:0];
            CSR_THRESHOLD: threshold_ff <= pwdata[FRAC_BITS-1:0];
            CSR_DEPTH:     depth_ff     <= pwdata[COEF_BITS-1:0];
            CSR_EXT_KEY:   ext_key_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_ATTACK:    prdata = CSR_DATA_BITS'(attack_ff);
         CSR_RELEASE:   prdata = CSR_DATA_BITS'(release_ff);
         CSR_THRESHOLD: prdata = CSR_DATA_BITS'(threshold_ff);
         CSR_DEPTH:     prdata = CSR_DATA_BITS'(depth_ff);
         CSR_EXT_KEY:   prdata = CSR_DATA_BITS'(ext_key_ff);
         default:       prdata = '0;
      endcase
   end

   assign attack_coef      = attack_ff;
   assign release_coef     = release_ff;
   assign duck_threshold   = threshold_ff;
   assign duck_depth       = depth_ff;
   assign use_external_key = ext_key_ff;

endmodule

// ----- rtl/sdc_mul.sv -----
module sdc_mul
   import sdc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF,
   localparam int BW = (COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS,
   localparam int PW = SAMPLE_BITS + BW + 1
) (
   input  logic                          clock,
   input  logic signed [SAMPLE_BITS-1:0] op_a,
   input  logic        [BW-1:0]          op_b,
   output logic signed [PW-1:0]          prod
);

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   // operand b is always a magnitude: widen with a zero sign bit
   assign prod_in = op_a * $signed({1'b0, op_b});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/sdc_core.sv -----
module sdc_core
   import sdc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] in_left,
   input  logic signed [SAMPLE_BITS-1:0] in_right,
   input  logic signed [SAMPLE_BITS-1:0] key_left,
   input  logic signed [SAMPLE_BITS-1:0] key_right,
   input  logic [COEF_BITS-1:0]          attack_coef,
   input  logic [COEF_BITS-1:0]          release_coef,
   input  logic [SAMPLE_BITS-2:0]        duck_threshold,
   input  logic [COEF_BITS-1:0]          duck_depth,
   input  logic                          use_external_key,
   input  logic                          out_free,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] out_left,
   output logic signed [SAMPLE_BITS-1:0] out_right
);

   localparam int FRAC_BITS = SAMPLE_BITS - 1;
   localparam int BW = (COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS;
   localparam int PW = SAMPLE_BITS + BW + 1;
   localparam logic signed [PW-1:0] UNITY_W = PW'(1) << FRAC_BITS;
   localparam logic [SAMPLE_BITS-1:0] GAIN_ONE = SAMPLE_BITS'(1) << FRAC_BITS;

   sdc_state_type state_ff, state_in;

   logic        [FRAC_BITS-1:0]   key_ff, key_in;
   logic        [FRAC_BITS-1:0]   env_ff, env_in;
   logic signed [SAMPLE_BITS-1:0] l_ff, l_in;
   logic signed [SAMPLE_BITS-1:0] r_ff, r_in;
   logic        [SAMPLE_BITS-1:0] gain_ff, gain_in;
   logic signed [SAMPLE_BITS-1:0] outl_ff, outl_in;

   logic signed [SAMPLE_BITS-1:0] op_a;
   logic        [BW-1:0]          op_b;
   logic signed [PW-1:0]          prod;

   logic        [FRAC_BITS-1:0]   ka, kb;
   logic        [COEF_BITS-1:0]   coef_sel;
   logic signed [SAMPLE_BITS-1:0] env_diff;
   logic signed [PW-1:0]          env_sum;
   logic        [FRAC_BITS-1:0]   over;
   logic signed [PW-1:0]          red;
   logic signed [PW-1:0]          prod_shift;

   // magnitude, full-scale negative saturates to the largest level
   function automatic logic [FRAC_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] a;
      a = v[SAMPLE_BITS-1] ? -v : v;
      return a[FRAC_BITS] ? {FRAC_BITS{1'b1}} : a[FRAC_BITS-1:0];
   endfunction

   sdc_mul #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign ka = use_external_key ? mag(key_left)  : mag(in_left);
   assign kb = use_external_key ? mag(key_right) : mag(in_right);

   assign coef_sel   = (key_ff > env_ff) ? attack_coef : release_coef;
   assign env_diff   = $signed({1'b0, env_ff}) - $signed({1'b0, key_ff});
   assign env_sum    = (prod >>> COEF_BITS) + $signed({1'b0, key_ff});
   assign over       = (env_ff > duck_threshold) ? env_ff - duck_threshold : '0;
   // doubling folded into the shift
   assign red        = prod >>> (COEF_BITS - 1);
   assign prod_shift = prod >>> FRAC_BITS;

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      env_in   = env_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      gain_in  = gain_ff;
      outl_in  = outl_ff;
      // default operands keep the right-channel product steady while waiting
      op_a     = r_ff;
      op_b     = BW'(gain_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = (ka > kb) ? ka : kb;
               l_in     = in_left;
               r_in     = in_right;
               state_in = S_ENV_MUL;
            end
         end
         S_ENV_MUL: begin
            op_a     = env_diff;
            op_b     = BW'(coef_sel);
            state_in = S_ENV;
         end
         S_ENV: begin
            env_in   = env_sum[FRAC_BITS-1:0];
            state_in = S_RED_MUL;
         end
         S_RED_MUL: begin
            op_a     = $signed({1'b0, over});
            op_b     = BW'(duck_depth);
            state_in = S_GAIN;
         end
         S_GAIN: begin
            if (red >= UNITY_W) begin
               gain_in = '0;
            end else begin
               gain_in = SAMPLE_BITS'(UNITY_W - red);
            end
            state_in = S_L_MUL;
         end
         S_L_MUL: begin
            op_a     = l_ff;
            state_in = S_R_MUL;
         end
         S_R_MUL: begin
            outl_in  = prod_shift[SAMPLE_BITS-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         env_ff   <= '0;
      end else begin
         state_ff <= state_in;
         env_ff   <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      gain_ff <= gain_in;
      outl_ff <= outl_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE);
   assign out_left  = outl_ff;
   assign out_right = prod_shift[SAMPLE_BITS-1:0];

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_ENV_MUL))
      else $error("accepted frame did not start the sequence");

   a_env_between: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENV) |=>
         ((env_ff >= key_ff) || (env_ff >= $past(env_ff))) &&
         ((env_ff <= key_ff) || (env_ff <= $past(env_ff))))
      else $error("envelope left the span between key and previous level");

   a_gain_unity: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_L_MUL) |-> (gain_ff <= GAIN_ONE))
      else $error("gain above unity");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> (state_ff == S_DONE && $stable(outl_ff)))
      else $error("result dropped while output stage busy");
`endif

endmodule

// ----- rtl/sidechain_ducking_compressor_unit.sv -----
// a frame passes from the input transfer to rsp_valid through the sequencer, longer
// while rsp_stall holds; a new frame is taken only after four passes through the one
// shared multiplier (envelope, reduction, left, right) under the sequencer; the finished
// frame sits in an output register, so a new frame is taken meanwhile
// reset clears the envelope and rsp_valid and restores the register defaults
module sidechain_ducking_compressor_unit
   import sdc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_in_left,
   input  logic signed [SAMPLE_BITS-1:0] req_in_right,
   input  logic signed [SAMPLE_BITS-1:0] req_key_left,
   input  logic signed [SAMPLE_BITS-1:0] req_key_right,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   logic [COEF_BITS-1:0]   attack_coef;
   logic [COEF_BITS-1:0]   release_coef;
   logic [SAMPLE_BITS-2:0] duck_threshold;
   logic [COEF_BITS-1:0]   duck_depth;
   logic                   use_external_key;

   logic                          core_done;
   logic signed [SAMPLE_BITS-1:0] core_left;
   logic signed [SAMPLE_BITS-1:0] core_right;
   logic                          out_free;
   logic                          out_load;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff;

   sdc_csr #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (csr_psel),
      .penable          (csr_penable),
      .pwrite           (csr_pwrite),
      .paddr            (csr_paddr),
      .pwdata           (csr_pwdata),
      .prdata           (csr_prdata),
      .attack_coef      (attack_coef),
      .release_coef     (release_coef),
      .duck_threshold   (duck_threshold),
      .duck_depth       (duck_depth),
      .use_external_key (use_external_key)
   );

   sdc_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .in_left          (req_in_left),
      .in_right         (req_in_right),
      .key_left         (req_key_left),
      .key_right        (req_key_right),
      .attack_coef      (attack_coef),
      .release_coef     (release_coef),
      .duck_threshold   (duck_threshold),
      .duck_depth       (duck_depth),
      .use_external_key (use_external_key),
      .out_free         (out_free),
      .done             (core_done),
      .out_left         (core_left),
      .out_right        (core_right)
   );

   // output stage takes a frame once the previous one has had its transfer
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = core_done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_left_ff  <= core_left;
         rsp_right_ff <= core_right;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;
   assign csr_pready    = 1'b1;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench
   import sdc_pkg::*;
();

   localparam int SB = SAMPLE_BITS_DEF;
   localparam int CB = COEF_BITS_DEF;
   localparam int FB = SB - 1;
   localparam longint LEVEL_MAX = (longint'(1) << FB) - 1;
   localparam longint UNITY = longint'(1) << FB;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_FRAMES = 154;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [SB-1:0] in_left;
      logic signed [SB-1:0] in_right;
      logic signed [SB-1:0] key_left;
      logic signed [SB-1:0] key_right;
   } frame_in_type;

   typedef struct {
      logic signed [SB-1:0] out_left;
      logic signed [SB-1:0] out_right;
   } ducked_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SB-1:0] req_in_left = '0;
   logic signed [SB-1:0] req_in_right = '0;
   logic signed [SB-1:0] req_key_left = '0;
   logic signed [SB-1:0] req_key_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SB-1:0] rsp_out_left;
   logic signed [SB-1:0] rsp_out_right;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // shadow copy of the register file and the envelope
   logic [CB-1:0] attack_coef = CB'(ATTACK_RESET);
   logic [CB-1:0] release_coef = CB'(RELEASE_RESET);
   logic [FB-1:0] duck_threshold = FB'(THRESHOLD_RESET);
   logic [CB-1:0] duck_depth = CB'(DEPTH_RESET);
   logic use_external_key = 1'b1;
   logic [FB-1:0] envelope_level = '0;

   frame_in_type pending_frames[$];
   ducked_frame_type ducked_q[$];
   frame_in_type cur_frame;
   int gap_cnt = 0;
   int stall_cnt = 0;
   int send_gap_max = 0;
   int recv_stall_max = 0;
   int frames_queued = 0;
   int frames_accepted = 0;
   int mismatches = 0;
   int cycle_count = 0;

   sidechain_ducking_compressor_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .req_key_left(req_key_left),
      .req_key_right(req_key_right),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   // magnitude with the most negative sample saturated
   function automatic longint level_of(input logic signed [SB-1:0] s);
      longint m;
      m = longint'(s);
      if (m < 0) begin
         m = -m;
      end
      return (m > LEVEL_MAX) ? LEVEL_MAX : m;
   endfunction

   // advances the envelope and returns the ducked stereo frame
   function automatic ducked_frame_type duck_frame(input frame_in_type f);
      longint lvl_a, lvl_b, key_lvl, env, coef, over, red, gain;
      ducked_frame_type res;
      if (use_external_key) begin
         lvl_a = level_of(f.key_left);
         lvl_b = level_of(f.key_right);
      end else begin
         lvl_a = level_of(f.in_left);
         lvl_b = level_of(f.in_right);
      end
      key_lvl = (lvl_a > lvl_b) ? lvl_a : lvl_b;
      env = longint'(envelope_level);
      coef = (key_lvl > env) ? longint'(attack_coef) : longint'(release_coef);
      env = key_lvl + (((env - key_lvl) * coef) >>> CB);
      envelope_level = FB'(env);
      over = env - longint'(duck_threshold);
      if (over < 0) begin
         over = 0;
      end
      red = (over * longint'(duck_depth) * 2) >>> CB;
      gain = UNITY - red;
      if (gain < 0) begin
         gain = 0;
      end
      res.out_left = SB'((longint'(f.in_left) * gain) >>> FB);
      res.out_right = SB'((longint'(f.in_right) * gain) >>> FB);
      return res;
   endfunction

   function automatic logic signed [SB-1:0] pick_sample(input int style);
      logic signed [SB-1:0] s;
      case (style)
         1: begin
            s = SB'(int'($urandom_range(0, 2047)) - 1024);
         end
         2: begin
            case ($urandom_range(0, 5))
               0: s = {1'b1, {FB{1'b0}}};
               1: s = {1'b0, {FB{1'b1}}};
               2: s = '1;
               3: s = '0;
               4: s = SB'(1);
               default: s = {1'b1, {(FB-1){1'b0}}, 1'b1};
            endcase
         end
         default: begin
            s = SB'($urandom());
         end
      endcase
      return s;
   endfunction

   // style 3 pairs full-range random main samples with a quiet key
   function automatic frame_in_type random_frame(input int style);
      frame_in_type f;
      f.in_left = pick_sample(style == 3 ? 0 : style);
      f.in_right = pick_sample(style == 3 ? 0 : style);
      f.key_left = pick_sample(style == 3 ? 1 : style);
      f.key_right = pick_sample(style == 3 ? 1 : style);
      return f;
   endfunction

   function automatic frame_in_type make_frame(input int l, r, kl, kr);
      frame_in_type f;
      f.in_left = SB'(l);
      f.in_right = SB'(r);
      f.key_left = SB'(kl);
      f.key_right = SB'(kr);
      return f;
   endfunction

   task automatic queue_frame(input frame_in_type f);
      pending_frames.push_back(f);
      frames_queued++;
   endtask

   task automatic queue_directed();
      queue_frame(make_frame(-32768, 32767, -32768, 32767));
      queue_frame(make_frame(32767, -32768, 32767, -32768));
      queue_frame(make_frame(0, 0, 0, 0));
      queue_frame(make_frame(-1, 1, -1, 1));
      queue_frame(make_frame(16384, -16384, 0, -32767));
      queue_frame(make_frame(-32768, -32768, 0, 0));
      queue_frame(make_frame(32767, 32767, -32768, -32768));
      queue_frame(make_frame(0, 0, 0, 0));
   endtask

   // runs of one signal style so the envelope sees attack and release stretches
   task automatic queue_bursts(input int count);
      int style;
      int run;
      while (count > 0) begin
         style = $urandom_range(0, 3);
         run = $urandom_range(1, 30);
         if (run > count) begin
            run = count;
         end
         repeat (run) queue_frame(random_frame(style));
         count -= run;
      end
   endtask

   task automatic settle();
      do @(negedge clock); while (frames_accepted != frames_queued || ducked_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input sdc_csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] want_rd;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      want_rd = '0;
      case (idx)
         CSR_ATTACK: begin
            attack_coef = value[CB-1:0];
            want_rd = CSR_DATA_BITS'(attack_coef);
         end
         CSR_RELEASE: begin
            release_coef = value[CB-1:0];
            want_rd = CSR_DATA_BITS'(release_coef);
         end
         CSR_THRESHOLD: begin
            duck_threshold = value[FB-1:0];
            want_rd = CSR_DATA_BITS'(duck_threshold);
         end
         CSR_DEPTH: begin
            duck_depth = value[CB-1:0];
            want_rd = CSR_DATA_BITS'(duck_depth);
         end
         CSR_EXT_KEY: begin
            use_external_key = value[0];
            want_rd = CSR_DATA_BITS'(use_external_key);
         end
         default: ;
      endcase
      // address still held, so the read port shows the new value
      @(negedge clock);
      if (csr_prdata !== want_rd) begin
         report_mismatch("register read back", csr_prdata, want_rd);
      end
   endtask

   task automatic apply_settings(input logic [CSR_DATA_BITS-1:0] att, rel, thr, dep, ext);
      write_csr(CSR_ATTACK, att);
      write_csr(CSR_RELEASE, rel);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_DEPTH, dep);
      write_csr(CSR_EXT_KEY, ext);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin : frame_driver
      bit free;
      frame_in_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt = 0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            ducked_q.push_back(duck_frame(cur_frame));
            frames_accepted++;
            free = 1'b1;
            gap_cnt = $urandom_range(0, send_gap_max);
         end
         if (free) begin
            if (gap_cnt > 0) begin
               gap_cnt--;
               req_valid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
               nxt = pending_frames.pop_front();
               cur_frame = nxt;
               req_in_left <= nxt.in_left;
               req_in_right <= nxt.in_right;
               req_key_left <= nxt.key_left;
               req_key_right <= nxt.key_right;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      ducked_frame_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (ducked_q.size() == 0) begin
               report_mismatch("transfer with nothing expected, out_left", rsp_out_left, 0);
            end else begin
               want = ducked_q.pop_front();
               if (rsp_out_left !== want.out_left) begin
                  report_mismatch("out_left", rsp_out_left, want.out_left);
               end
               if (rsp_out_right !== want.out_right) begin
                  report_mismatch("out_right", rsp_out_right, want.out_right);
               end
            end
            stall_cnt = $urandom_range(0, recv_stall_max);
         end
         if (stall_cnt > 0) begin
            rsp_stall <= 1'b1;
            stall_cnt--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int p;
      logic [CSR_DATA_BITS-1:0] att, rel, thr, dep, ext;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: zero depth, so unity gain
      queue_directed();
      settle();
      // zero attack makes the envelope jump to the key
      send_gap_max = 4;
      recv_stall_max = 4;
      apply_settings('0, 32'h0000_8000, 32'h0000_1000, 32'h0000_FFFF, 32'd1);
      queue_directed();
      settle();
      // keyed from the main samples; upper bits set to check the masking
      apply_settings('1, 32'hFFFF_0000, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      queue_directed();
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         send_gap_max = (p % 3 == 0) ? 0 : 4;
         recv_stall_max = (p % 4 == 0) ? 0 : 4;
         case (p)
            0: begin
               apply_settings('1, '1, '1, '1, 32'd1);
            end
            1: begin
               apply_settings('0, '0, '0, '0, '0);
            end
            default: begin
               att = $urandom_range(0, 1) ? ($urandom() | 32'h0000_FC00) : $urandom();
               rel = $urandom_range(0, 1) ? ($urandom() | 32'h0000_FF00) : $urandom();
               thr = $urandom();
               dep = $urandom();
               ext = $urandom();
               apply_settings(att, rel, thr, dep, ext);
            end
         endcase
         if (p == 2) begin
            // sender holds off until every frame so far has come back
            queue_bursts(PHASE_FRAMES / 2);
            settle();
            queue_bursts(PHASE_FRAMES - PHASE_FRAMES / 2);
         end else begin
            queue_bursts(PHASE_FRAMES);
         end
         settle();
      end

      if (ducked_q.size() != 0) begin
         report_mismatch("frames never delivered", ducked_q.size(), 0);
      end
      if (mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
